@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LLB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/llb_pkg.sv @@
// ----------------------------------------------------------------------------
// Lagrange line basis package
// Shared widths, request type, state encodings and node helper.
// ----------------------------------------------------------------------------
`default_nettype none

package llb_pkg;

  localparam int X_W      = 20;
  localparam int ORD_W    = 4;
  localparam int RES_W    = 32;
  localparam int RES_FRAC = 24;
  localparam int ACC_W    = 35;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 35'sd8589934592;
  localparam logic signed [ACC_W-1:0] ACC_MIN = -35'sd8589934592;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic                  deriv;
    logic [ORD_W-1:0]      order;
  } item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROW,
    B_SETUP,
    B_GO,
    B_WAIT,
    B_UPDATE,
    B_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL_LO,
    M_MUL_HI,
    M_BIAS,
    M_DIV,
    M_DONE
  } mdr_state_t;

  typedef enum logic [1:0] {
    OP_V,
    OP_G,
    OP_D
  } op_t;

  // Node k scaled by the order: 0, p, then k-1.
  function automatic logic [ORD_W-1:0] node_scaled(input logic [ORD_W:0] k,
                                                   input logic [ORD_W-1:0] p);
    logic [ORD_W-1:0] r;
    if (k == '0) begin
      r = '0;
    end else if (k == (ORD_W+1)'(1)) begin
      r = p;
    end else begin
      r = ORD_W'(k - (ORD_W+1)'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/llb_front.sv @@
// ----------------------------------------------------------------------------
// Lagrange line basis front end
// Holds the order register, accepts requests and clamps their order.
// ----------------------------------------------------------------------------
`default_nettype none

module llb_front #(
  parameter int MAX_ORDER = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [llb_pkg::X_W-1:0] point_x,
  input  logic                           want_derivative,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [llb_pkg::ORD_W-1:0]      cfg_data,
  input  logic                           q_full,
  output logic                           push,
  output llb_pkg::item_t                 push_item
);

  logic [llb_pkg::ORD_W-1:0] poly_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_order <= llb_pkg::ORD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      poly_order <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign push      = start && !q_full;

  always_comb begin
    push_item.x     = point_x;
    push_item.deriv = want_derivative;
    if (poly_order > MAX_ORDER) begin
      push_item.order = llb_pkg::ORD_W'(MAX_ORDER);
    end else begin
      push_item.order = poly_order;
    end
  end

endmodule

`default_nettype wire

@@ rtl/llb_queue.sv @@
// ----------------------------------------------------------------------------
// Lagrange line basis request queue
// Two-entry queue between the front end and the evaluation sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module llb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  llb_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output llb_pkg::item_t head
);

  llb_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

endmodule

`default_nettype wire

@@ rtl/llb_mdr.sv @@
// ----------------------------------------------------------------------------
// Lagrange line basis multiply-divide-round unit
// Computes round(a * m / den) with ties away from zero over several cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module llb_mdr #(
  parameter int N_W = 26,
  parameter int XF  = 16,
  localparam int DIV_W = ((llb_pkg::ACC_W + N_W + 1 + 7) / 8) * 8,
  localparam int Q_W   = DIV_W + 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic signed [llb_pkg::ACC_W-1:0] a,
  input  logic signed [N_W-1:0]            m,
  input  logic [llb_pkg::ORD_W-1:0]        d,
  input  logic                             scaled,
  output logic                             done,
  output logic signed [Q_W-1:0]            q
);

  localparam int AW    = llb_pkg::ACC_W;
  localparam int LO_W  = AW / 2;
  localparam int HI_W  = AW - LO_W;
  localparam int P_W   = AW + N_W;
  localparam int STEPS = DIV_W / 8;
  localparam int SC_W  = $clog2(STEPS);

  llb_pkg::mdr_state_t state, state_next;

  logic [AW-1:0]                 amag;
  logic [N_W-1:0]                mmag;
  logic                          neg;
  logic [llb_pkg::ORD_W-1:0]     dd;
  logic                          sc;
  logic [LO_W+N_W-1:0]           plo;
  logic [HI_W+N_W-1:0]           phi;
  logic [DIV_W-1:0]              tq;
  logic [llb_pkg::ORD_W-1:0]     rem;
  logic [SC_W-1:0]               step;

  logic [HI_W-1:0]               mul_in;
  logic [HI_W+N_W-1:0]           prod;
  logic [P_W-1:0]                pfull;
  logic [P_W:0]                  biased;
  logic [DIV_W-1:0]              tq_step;
  logic [llb_pkg::ORD_W-1:0]     rem_step;
  logic signed [Q_W-1:0]         qmag;

  always_comb begin
    state_next = state;
    case (state)
      llb_pkg::M_IDLE:   if (go) state_next = llb_pkg::M_MUL_LO;
      llb_pkg::M_MUL_LO: state_next = llb_pkg::M_MUL_HI;
      llb_pkg::M_MUL_HI: state_next = llb_pkg::M_BIAS;
      llb_pkg::M_BIAS:   state_next = llb_pkg::M_DIV;
      llb_pkg::M_DIV:    if (step == SC_W'(STEPS - 1)) state_next = llb_pkg::M_DONE;
      llb_pkg::M_DONE:   state_next = llb_pkg::M_IDLE;
      default:           state_next = llb_pkg::M_IDLE;
    endcase
  end

  always_comb begin
    qmag = $signed({1'b0, tq});
    done = (state == llb_pkg::M_DONE);
    q    = neg ? -qmag : qmag;
  end

  always_comb begin
    if (state == llb_pkg::M_MUL_LO) begin
      mul_in = HI_W'(amag[LO_W-1:0]);
    end else begin
      mul_in = amag[AW-1:LO_W];
    end
    prod  = (HI_W+N_W)'(mul_in) * (HI_W+N_W)'(mmag);
    pfull = {phi, {LO_W{1'b0}}} + P_W'(plo);
    if (sc) begin
      biased = ((P_W+1)'(pfull) + ((P_W+1)'(dd) << (XF - 1))) >> XF;
    end else begin
      biased = (P_W+1)'(pfull) + (P_W+1)'(dd >> 1);
    end
  end

  always_comb begin
    logic [llb_pkg::ORD_W:0] r5;
    logic [llb_pkg::ORD_W-1:0] r;
    logic [DIV_W-1:0] t;
    r = rem;
    t = tq;
    for (int k = 0; k < 8; k++) begin
      r5 = {r, t[DIV_W-1]};
      t  = {t[DIV_W-2:0], 1'b0};
      if (r5 >= {1'b0, dd}) begin
        r5   = r5 - {1'b0, dd};
        t[0] = 1'b1;
      end
      r = r5[llb_pkg::ORD_W-1:0];
    end
    tq_step  = t;
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llb_pkg::M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      llb_pkg::M_IDLE: begin
        if (go) begin
          amag <= a[AW-1] ? AW'(-a) : AW'(a);
          mmag <= m[N_W-1] ? N_W'(-m) : N_W'(m);
          neg  <= a[AW-1] ^ m[N_W-1];
          dd   <= d;
          sc   <= scaled;
        end
      end
      llb_pkg::M_MUL_LO: plo <= prod[LO_W+N_W-1:0];
      llb_pkg::M_MUL_HI: phi <= prod;
      llb_pkg::M_BIAS: begin
        tq   <= DIV_W'(biased);
        rem  <= '0;
        step <= '0;
      end
      llb_pkg::M_DIV: begin
        tq   <= tq_step;
        rem  <= rem_step;
        step <= SC_W'(step + 1'b1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/llb_back.sv @@
// ----------------------------------------------------------------------------
// Lagrange line basis evaluation sequencer
// Walks basis and node indexes, applies the product rule, emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module llb_back #(
  parameter int X_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  llb_pkg::item_t                   head,
  output logic                             pop,
  output logic                             result_valid,
  output logic [llb_pkg::ORD_W-1:0]        basis_index,
  output logic signed [llb_pkg::RES_W-1:0] basis_result,
  output logic                             last
);

  localparam int OW    = llb_pkg::ORD_W;
  localparam int AW    = llb_pkg::ACC_W;
  localparam int XB_W  = (llb_pkg::X_W > X_FRAC_BITS + 1) ? llb_pkg::X_W : X_FRAC_BITS + 1;
  localparam int N_W   = XB_W + OW + 2;
  localparam int DIV_W = ((AW + N_W + 1 + 7) / 8) * 8;
  localparam int Q_W   = DIV_W + 1;

  localparam logic signed [AW-1:0] R_MAX =
    $signed({{(AW-llb_pkg::RES_W+1){1'b0}}, {(llb_pkg::RES_W-1){1'b1}}});
  localparam logic signed [AW-1:0] R_MIN =
    $signed({{(AW-llb_pkg::RES_W+1){1'b1}}, {(llb_pkg::RES_W-1){1'b0}}});

  llb_pkg::back_state_t state, state_next;
  llb_pkg::item_t       cur;
  llb_pkg::op_t         op;

  logic [OW-1:0]          i;
  logic [OW:0]            j;
  logic signed [N_W-1:0]  nreg;
  logic signed [N_W-1:0]  pnreg;
  logic [OW-1:0]          dreg;
  logic signed [AW-1:0]   v;
  logic signed [AW-1:0]   g;
  logic signed [Q_W-1:0]  t0;
  logic signed [Q_W-1:0]  t1;
  logic signed [Q_W-1:0]  t2;

  logic                   mdr_go;
  logic                   mdr_done;
  logic signed [AW-1:0]   mdr_a;
  logic signed [N_W-1:0]  mdr_m;
  logic                   mdr_scaled;
  logic signed [Q_W-1:0]  mdr_q;

  logic [OW-1:0]          ti;
  logic [OW-1:0]          tj;
  logic signed [OW+1:0]   dsig;
  logic signed [N_W-1:0]  px;
  logic signed [N_W-1:0]  tjs;
  logic signed [N_W-1:0]  nraw;
  logic signed [N_W-1:0]  pos_p;
  logic signed [Q_W:0]    gsum;
  logic signed [AW-1:0]   rsel;
  logic                   row_end;
  logic                   skip_j;

  function automatic logic signed [AW-1:0] clamp_acc(input logic signed [Q_W:0] val);
    logic signed [AW-1:0] r;
    if (val > (Q_W+1)'(llb_pkg::ACC_MAX)) begin
      r = llb_pkg::ACC_MAX;
    end else if (val < (Q_W+1)'(llb_pkg::ACC_MIN)) begin
      r = llb_pkg::ACC_MIN;
    end else begin
      r = AW'(val);
    end
    return r;
  endfunction

  always_comb begin
    ti    = llb_pkg::node_scaled({1'b0, i}, cur.order);
    tj    = llb_pkg::node_scaled(j, cur.order);
    dsig  = $signed({2'b00, ti}) - $signed({2'b00, tj});
    px    = N_W'($signed({1'b0, cur.order})) * N_W'(cur.x);
    tjs   = N_W'($signed({1'b0, tj}));
    nraw  = px - (tjs <<< X_FRAC_BITS);
    pos_p = N_W'($signed({1'b0, cur.order}));
    gsum  = (Q_W+1)'(t1) + (Q_W+1)'(t2);
    rsel  = cur.deriv ? g : v;
    row_end = (j > {1'b0, cur.order});
    skip_j  = (j == {1'b0, i});
  end

  always_comb begin
    state_next = state;
    case (state)
      llb_pkg::B_IDLE:   if (!q_empty) state_next = llb_pkg::B_ROW;
      llb_pkg::B_ROW:    state_next = llb_pkg::B_SETUP;
      llb_pkg::B_SETUP: begin
        if (row_end) begin
          state_next = llb_pkg::B_EMIT;
        end else if (!skip_j) begin
          state_next = llb_pkg::B_GO;
        end
      end
      llb_pkg::B_GO:     state_next = llb_pkg::B_WAIT;
      llb_pkg::B_WAIT: begin
        if (mdr_done) begin
          state_next = (op == llb_pkg::OP_D) ? llb_pkg::B_UPDATE : llb_pkg::B_GO;
        end
      end
      llb_pkg::B_UPDATE: state_next = llb_pkg::B_SETUP;
      llb_pkg::B_EMIT: begin
        state_next = (i == cur.order) ? llb_pkg::B_IDLE : llb_pkg::B_ROW;
      end
      default:           state_next = llb_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == llb_pkg::B_IDLE) && !q_empty;
    mdr_go     = (state == llb_pkg::B_GO);
    mdr_a      = (op == llb_pkg::OP_G) ? g : v;
    mdr_m      = (op == llb_pkg::OP_D) ? pnreg : nreg;
    mdr_scaled = (op != llb_pkg::OP_D);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= llb_pkg::B_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == llb_pkg::B_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      llb_pkg::B_IDLE: begin
        if (!q_empty) begin
          cur <= head;
          i   <= '0;
        end
      end
      llb_pkg::B_ROW: begin
        v <= AW'(1) <<< llb_pkg::RES_FRAC;
        g <= '0;
        j <= '0;
      end
      llb_pkg::B_SETUP: begin
        if (!row_end) begin
          if (skip_j) begin
            j <= (OW+1)'(j + 1'b1);
          end else begin
            op <= llb_pkg::OP_V;
            if (dsig < 0) begin
              dreg  <= OW'(-dsig);
              nreg  <= -nraw;
              pnreg <= -pos_p;
            end else begin
              dreg  <= OW'(dsig);
              nreg  <= nraw;
              pnreg <= pos_p;
            end
          end
        end
      end
      llb_pkg::B_WAIT: begin
        if (mdr_done) begin
          case (op)
            llb_pkg::OP_V: begin
              t0 <= mdr_q;
              op <= llb_pkg::OP_G;
            end
            llb_pkg::OP_G: begin
              t1 <= mdr_q;
              op <= llb_pkg::OP_D;
            end
            default: t2 <= mdr_q;
          endcase
        end
      end
      llb_pkg::B_UPDATE: begin
        v <= clamp_acc((Q_W+1)'(t0));
        g <= clamp_acc(gsum);
        j <= (OW+1)'(j + 1'b1);
      end
      llb_pkg::B_EMIT: begin
        basis_index <= i;
        last        <= (i == cur.order);
        if (rsel > R_MAX) begin
          basis_result <= llb_pkg::RES_W'(R_MAX);
        end else if (rsel < R_MIN) begin
          basis_result <= llb_pkg::RES_W'(R_MIN);
        end else begin
          basis_result <= llb_pkg::RES_W'(rsel);
        end
        i <= OW'(i + 1'b1);
      end
      default: begin
      end
    endcase
  end

  llb_mdr #(
    .N_W (N_W),
    .XF  (X_FRAC_BITS)
  ) u_mdr (
    .clk    (clk),
    .rst    (rst),
    .go     (mdr_go),
    .a      (mdr_a),
    .m      (mdr_m),
    .d      (dreg),
    .scaled (mdr_scaled),
    .done   (mdr_done),
    .q      (mdr_q)
  );

endmodule

`default_nettype wire

@@ rtl/lagrange_line_basis_eval_core.sv @@
// Each point is evaluated row by row; each factor of a row takes three multiply-divide-round
// operations plus a setup and an update state.
// A two-entry request queue lets start be taken while a point is being evaluated.
// Results come one at a time with result_valid; the receiver cannot stall them.
// Synchronous reset clears the queue and sequencer and sets the order register to 1.
// ----------------------------------------------------------------------------
// Lagrange line basis evaluator
// Emits Lagrange basis values or derivatives on the reference line.
// ----------------------------------------------------------------------------
`default_nettype none

module lagrange_line_basis_eval_core #(
  parameter int MAX_ORDER   = 8,
  parameter int X_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [llb_pkg::X_W-1:0]   point_x,
  input  logic                             want_derivative,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [llb_pkg::ORD_W-1:0]        cfg_data,
  output logic                             result_valid,
  output logic [llb_pkg::ORD_W-1:0]        basis_index,
  output logic signed [llb_pkg::RES_W-1:0] basis_result,
  output logic                             last
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  llb_pkg::item_t push_item;
  llb_pkg::item_t head;

  llb_front #(
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .point_x         (point_x),
    .want_derivative (want_derivative),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .push            (push),
    .push_item       (push_item)
  );

  llb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  llb_back #(
    .X_FRAC_BITS (X_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .basis_index  (basis_index),
    .basis_result (basis_result),
    .last         (last)
  );

endmodule

`default_nettype wire

@@ rtl/llb_checker.sv @@
// ----------------------------------------------------------------------------
// Lagrange line basis port checker
// Checks result spacing and port behavior seen at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module llb_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic                             result_valid,
  input logic [llb_pkg::ORD_W-1:0]        basis_index,
  input logic                             last
);

  // result_valid is never high in the cycle after a result.
  `LLB_ASSERT_NEXT(a_result_gap, result_valid, !result_valid)
  // Configuration writes are never held off.
  `LLB_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)
  // The highest possible index can only be the final result of a point.
  `LLB_ASSERT_SAME(a_top_index_last, result_valid && basis_index == '1, last)

endmodule

bind lagrange_line_basis_eval_core llb_checker u_llb_checker (.*);

`default_nettype wire
